>>> sv/lr_pkg.sv
// lr_pkg: widths, codes and reset values for the line rasterizer.
// No dependencies; used by line_rasterizer.
package lr_pkg;

   localparam int COORD_BITS = 10;
   localparam int ERR_BITS   = COORD_BITS + 2;
   localparam int COLOR_BITS = 32;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [COORD_BITS-1:0] RESET_WIDTH  = COORD_BITS'(800);
   localparam logic [COORD_BITS-1:0] RESET_HEIGHT = COORD_BITS'(600);
   localparam logic [COORD_BITS-1:0] COORD_ONE    = COORD_BITS'(1);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ERR_BITS-1:0]   err_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_STEP = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

endpackage

>>> sv/line_rasterizer.sv
// line_rasterizer: eight-octant Bresenham line rasterizer; uses lr_pkg.
// Latency: a result is presented the cycle after its item is accepted.
// Throughput: one item per cycle while no unread result stalls the input;
// the error add, compare and subtract per step precede the result register.
// Reset: synchronous, active high; no line active, screen 800 x 600,
// result register empty.
module line_rasterizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [lr_pkg::COORD_BITS-1:0]  csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_action,
   input  logic [lr_pkg::COORD_BITS-1:0]  req_x_start,
   input  logic [lr_pkg::COORD_BITS-1:0]  req_y_start,
   input  logic [lr_pkg::COORD_BITS-1:0]  req_x_end,
   input  logic [lr_pkg::COORD_BITS-1:0]  req_y_end,
   input  logic [lr_pkg::COLOR_BITS-1:0]  req_line_color,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lr_pkg::COORD_BITS-1:0]  rsp_pixel_x,
   output logic [lr_pkg::COORD_BITS-1:0]  rsp_pixel_y,
   output logic [lr_pkg::COLOR_BITS-1:0]  rsp_pixel_color,
   output logic                           rsp_pixel_valid,
   output logic                           rsp_last_pixel,
   output logic                           rsp_rejected
);

   lr_pkg::coord_type width_ff, height_ff;
   lr_pkg::coord_type cur_x_ff, cur_y_ff, end_x_ff, end_y_ff;
   lr_pkg::coord_type cur_x_in, cur_y_in, end_x_in, end_y_in;
   lr_pkg::coord_type major_ff, minor_ff, major_in, minor_in;
   lr_pkg::err_type   err_ff, err_in;
   logic              x_major_ff, x_neg_ff, y_neg_ff, active_ff;
   logic              x_major_in, x_neg_in, y_neg_in, active_in;
   lr_pkg::color_type color_ff, color_in;

   logic              rsp_valid_ff, rsp_valid_in;
   lr_pkg::coord_type rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   lr_pkg::color_type rsp_color_ff, rsp_color_in;
   logic              rsp_pix_ff, rsp_pix_in, rsp_last_ff, rsp_last_in;
   logic              rsp_rej_ff, rsp_rej_in;

   logic              req_take, is_load, reject;
   logic              ld_x_neg, ld_y_neg, ld_x_major;
   lr_pkg::coord_type ld_dx, ld_dy;
   lr_pkg::err_type   err_sum;
   logic              minor_move;
   lr_pkg::coord_type x_inc, y_inc;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign is_load   = (req_action == lr_pkg::ACT_LOAD);

   // load setup
   assign reject = (req_x_start >= width_ff) || (req_x_end >= width_ff) ||
                   (req_y_start >= height_ff) || (req_y_end >= height_ff);
   assign ld_x_neg   = req_x_end < req_x_start;
   assign ld_y_neg   = req_y_end < req_y_start;
   assign ld_dx      = ld_x_neg ? req_x_start - req_x_end : req_x_end - req_x_start;
   assign ld_dy      = ld_y_neg ? req_y_start - req_y_end : req_y_end - req_y_start;
   assign ld_x_major = ld_dx >= ld_dy;

   // step datapath
   assign err_sum    = err_ff + lr_pkg::ERR_BITS'(minor_ff);
   assign minor_move = err_sum >= lr_pkg::ERR_BITS'(major_ff);
   assign x_inc = x_neg_ff ? cur_x_ff - lr_pkg::COORD_ONE : cur_x_ff + lr_pkg::COORD_ONE;
   assign y_inc = y_neg_ff ? cur_y_ff - lr_pkg::COORD_ONE : cur_y_ff + lr_pkg::COORD_ONE;

   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      end_x_in   = end_x_ff;
      end_y_in   = end_y_ff;
      major_in   = major_ff;
      minor_in   = minor_ff;
      err_in     = err_ff;
      x_major_in = x_major_ff;
      x_neg_in   = x_neg_ff;
      y_neg_in   = y_neg_ff;
      active_in  = active_ff;
      color_in   = color_ff;
      rsp_x_in     = '0;
      rsp_y_in     = '0;
      rsp_color_in = '0;
      rsp_pix_in   = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_rej_in   = 1'b0;
      if (is_load) begin
         if (reject) begin
            active_in  = 1'b0;
            rsp_rej_in = 1'b1;
         end else begin
            x_neg_in   = ld_x_neg;
            y_neg_in   = ld_y_neg;
            x_major_in = ld_x_major;
            major_in   = ld_x_major ? ld_dx : ld_dy;
            minor_in   = ld_x_major ? ld_dy : ld_dx;
            err_in     = lr_pkg::ERR_BITS'(major_in >> 1);
            cur_x_in   = req_x_start;
            cur_y_in   = req_y_start;
            end_x_in   = req_x_end;
            end_y_in   = req_y_end;
            color_in   = req_line_color;
            active_in  = !(req_x_start == req_x_end && req_y_start == req_y_end);
            rsp_x_in     = req_x_start;
            rsp_y_in     = req_y_start;
            rsp_color_in = req_line_color;
            rsp_pix_in   = 1'b1;
            rsp_last_in  = !active_in;
         end
      end else if (active_ff) begin
         err_in = minor_move ? err_sum - lr_pkg::ERR_BITS'(major_ff) : err_sum;
         if (x_major_ff) begin
            cur_x_in = x_inc;
            if (minor_move) begin
               cur_y_in = y_inc;
            end
         end else begin
            cur_y_in = y_inc;
            if (minor_move) begin
               cur_x_in = x_inc;
            end
         end
         active_in    = !(cur_x_in == end_x_ff && cur_y_in == end_y_ff);
         rsp_x_in     = cur_x_in;
         rsp_y_in     = cur_y_in;
         rsp_color_in = color_ff;
         rsp_pix_in   = 1'b1;
         rsp_last_in  = !active_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= lr_pkg::RESET_WIDTH;
         height_ff    <= lr_pkg::RESET_HEIGHT;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               lr_pkg::REG_SCREEN_WIDTH:  width_ff  <= csr_wdata;
               lr_pkg::REG_SCREEN_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_take) begin
            active_ff <= active_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         end_x_ff     <= end_x_in;
         end_y_ff     <= end_y_in;
         major_ff     <= major_in;
         minor_ff     <= minor_in;
         err_ff       <= err_in;
         x_major_ff   <= x_major_in;
         x_neg_ff     <= x_neg_in;
         y_neg_ff     <= y_neg_in;
         color_ff     <= color_in;
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_color_ff <= rsp_color_in;
         rsp_pix_ff   <= rsp_pix_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_rej_ff   <= rsp_rej_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_pixel_valid = rsp_pix_ff;
   assign rsp_last_pixel  = rsp_last_ff;
   assign rsp_rejected    = rsp_rej_ff;

`ifndef SYNTH
   a_reject_drops_line: assert property (@(posedge clock) disable iff (reset)
      req_take && is_load && reject |=> !active_ff && rsp_valid && rsp_rejected)
      else $error("rejected load left a line active");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      req_take && rsp_last_in |=> !active_ff && rsp_last_pixel)
      else $error("end pixel emitted but line still active");

   a_reject_no_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> !rsp_pixel_valid && !rsp_last_pixel)
      else $error("rejected result carries a pixel");

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      req_take && !is_load && !active_ff |=> !rsp_pixel_valid && !rsp_rejected)
      else $error("idle step produced a pixel");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");
`endif

endmodule
